/* rtl/bcfi_pkg.sv */
// shared constants and types for the bitcell to flux interval converter
package bcfi_pkg;

    localparam int CELL_W        = 8;
    localparam int POS_W         = 3;
    localparam int ACC_W         = 32;
    localparam int BIT_TIME_W    = 20;
    localparam int PADDR_W       = 2;
    localparam int PDATA_W       = 32;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = 1;
    localparam int QUEUE_CW      = 2;

    localparam logic [BIT_TIME_W-1:0] BIT_TIME_RESET = 20'd4000;
    localparam logic [PADDR_W-1:0]    ADDR_BIT_TIME  = 2'd0;

    // one queued byte with its classification
    typedef struct packed {
        logic [CELL_W-1:0] cell_byte;
        logic              track_end;
        logic [CELL_W-1:0] later_set;   // bit p: a transition lies below position p
    } q_item_t;

    typedef struct packed {
        logic    valid;
        q_item_t item;
    } head_t;

endpackage

/* rtl/bcfi_in_if.sv */
// input channel: one byte of bitcells per item
interface bcfi_in_if;
    import bcfi_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_byte;
    logic              track_end;

    modport source (output valid, output cell_byte, output track_end, input ready);
    modport sink   (input valid, input cell_byte, input track_end, output ready);
endinterface

/* rtl/bcfi_out_if.sv */
// output channel: one flux interval per item
interface bcfi_out_if;
    import bcfi_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACC_W-1:0] interval_ns;
    logic             run_last;
    logic             track_last;

    modport source (output valid, output interval_ns, output run_last, output track_last,
                    input ready);
    modport sink   (input valid, input interval_ns, input run_last, input track_last,
                    output ready);
endinterface

/* rtl/bcfi_front.sv */
// front end: accepts bytes, classifies transitions and queues them
module bcfi_front (
    input  logic           clk,
    input  logic           rst_n,
    bcfi_in_if.sink        cell_in,
    output bcfi_pkg::head_t head,
    input  logic           pop
);
    import bcfi_pkg::*;

    q_item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;
    logic [CELL_W-1:0]     later_set;
    logic                  push;

    // running or from the lsb up
    always_comb
    begin
        later_set    = '0;
        for (int p = 1; p < CELL_W; p++)
        begin
            later_set[p] = later_set[p-1] | cell_in.cell_byte[p-1];
        end
    end

    assign cell_in.ready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push          = cell_in.valid && cell_in.ready;

    assign head.valid    = (count_reg != '0);
    assign head.item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QUEUE_CW'(1);
            2'b01:   count_next = count_reg - QUEUE_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{cell_byte: cell_in.cell_byte,
                                       track_end: cell_in.track_end,
                                       later_set: later_set};
        end
    end

endmodule

/* rtl/bcfi_back.sv */
// back end: walks bitcells one per cycle while a byte is queued and the output is free, and emits held intervals
module bcfi_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bcfi_pkg::head_t                    head,
    output logic                               pop,
    input  logic [bcfi_pkg::BIT_TIME_W-1:0]    bit_time,
    bcfi_out_if.source                         interval_out
);
    import bcfi_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] held_reg;
    logic [ACC_W-1:0] held_next;
    logic             held_valid_reg;
    logic             held_valid_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             flush_reg;
    logic             flush_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [ACC_W-1:0] out_interval_reg;
    logic [ACC_W-1:0] out_interval_next;
    logic             out_run_last_reg;
    logic             out_run_last_next;
    logic             out_track_last_reg;
    logic             out_track_last_next;
    logic             load_out;

    logic             out_free;
    logic             active;
    logic             bit_now;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sat;
    logic [ACC_W:0]   tail_sum;
    logic [ACC_W-1:0] tail_sat;

    assign out_free = !out_valid_reg || interval_out.ready;
    assign active   = head.valid && out_free;
    assign bit_now  = head.item.cell_byte[pos_reg];

    assign acc_sum  = {1'b0, acc_reg} + {{(ACC_W + 1 - BIT_TIME_W){1'b0}}, bit_time};
    assign acc_sat  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    assign tail_sum = {1'b0, held_reg} + {1'b0, acc_reg};
    assign tail_sat = tail_sum[ACC_W] ? {ACC_W{1'b1}} : tail_sum[ACC_W-1:0];

    always_comb
    begin
        acc_next            = acc_reg;
        held_next           = held_reg;
        held_valid_next     = held_valid_reg;
        pos_next            = pos_reg;
        flush_next          = flush_reg;
        out_valid_next      = out_valid_reg && !interval_out.ready;
        out_interval_next   = out_interval_reg;
        out_run_last_next   = out_run_last_reg;
        out_track_last_next = out_track_last_reg;
        load_out            = 1'b0;
        pop                 = 1'b0;

        if (active)
        begin
            if (!flush_reg)
            begin
                if (bit_now)
                begin
                    if (held_valid_reg)
                    begin
                        load_out            = 1'b1;
                        out_interval_next   = held_reg;
                        out_run_last_next   = !head.item.later_set[pos_reg]
                                              && !head.item.track_end;
                        out_track_last_next = 1'b0;
                    end
                    held_next       = acc_sat;
                    held_valid_next = 1'b1;
                    acc_next        = '0;
                end
                else
                begin
                    acc_next = acc_sat;
                end
                // position wraps back to the msb after the lsb
                pos_next = pos_reg - POS_W'(1);
                if (pos_reg == '0)
                begin
                    if (head.item.track_end)
                    begin
                        flush_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            else
            begin
                if (held_valid_reg)
                begin
                    load_out            = 1'b1;
                    out_interval_next   = tail_sat;
                    out_run_last_next   = 1'b1;
                    out_track_last_next = 1'b1;
                end
                acc_next        = '0;
                held_next       = '0;
                held_valid_next = 1'b0;
                flush_next      = 1'b0;
                pop             = 1'b1;
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            pos_reg        <= POS_W'(CELL_W - 1);
            flush_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            acc_reg        <= acc_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            pos_reg        <= pos_next;
            flush_reg      <= flush_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_interval_reg   <= out_interval_next;
        out_run_last_reg   <= out_run_last_next;
        out_track_last_reg <= out_track_last_next;
    end

    assign interval_out.valid       = out_valid_reg;
    assign interval_out.interval_ns = out_interval_reg;
    assign interval_out.run_last    = out_run_last_reg;
    assign interval_out.track_last  = out_track_last_reg;

endmodule

/* rtl/bitcell_to_flux_intervals.sv */
// top level of the bitcell to flux interval converter
//
// channel       dir  handshake      payload
// cell_in       in   valid/ready    cell_byte[7:0], track_end
// interval_out  out  valid/ready    interval_ns[31:0], run_last, track_last
// apb           in   psel/penable   bit time[19:0] at byte address 0
//
// the back end walks a byte one bitcell per cycle through the saturating adder while
// the output is free, and takes one extra flush step when track_end is set
// a two entry queue takes the next byte while the current one is walked
// reset clears the queue, accumulator, held interval and output valid flag;
// the bit time returns to 4000
// an output stall freezes the bit sequencer until the item is taken
module bitcell_to_flux_intervals (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bcfi_pkg::PADDR_W-1:0]    paddr,
    input  logic [bcfi_pkg::PDATA_W-1:0]    pwdata,
    output logic [bcfi_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    bcfi_in_if.sink                         cell_in,
    bcfi_out_if.source                      interval_out
);
    import bcfi_pkg::*;

    logic [BIT_TIME_W-1:0] bit_time_reg;
    logic [BIT_TIME_W-1:0] bit_time_next;
    head_t                 head;
    logic                  pop;

    // single register at byte address 0; other addresses ignore writes and read zero
    assign pready = 1'b1;

    always_comb
    begin
        bit_time_next = bit_time_reg;
        if (psel && penable && pwrite && (paddr == ADDR_BIT_TIME))
        begin
            bit_time_next = pwdata[BIT_TIME_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_BIT_TIME) ? PDATA_W'(bit_time_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg <= BIT_TIME_RESET;
        end
        else
        begin
            bit_time_reg <= bit_time_next;
        end
    end

    // front: accept and classify, queue ahead of the sequencer
    bcfi_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cell_in (cell_in),
        .head    (head),
        .pop     (pop)
    );

    // back: bit sequencer, held interval and output register
    bcfi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .bit_time     (bit_time_reg),
        .interval_out (interval_out)
    );

endmodule

/* tb/sv/bitcell_to_flux_intervals_tb.sv */
// self-checking testbench for the bitcell to flux interval converter
`timescale 1ns / 100ps

module bitcell_to_flux_intervals_tb;
    import bcfi_pkg::*;

    // unused register slot, writes here must leave the bit time alone
    localparam logic [PADDR_W-1:0]    ADDR_SPARE     = 2'd3;
    localparam logic [BIT_TIME_W-1:0] BIT_TIME_MAX   = 20'd1000000;
    localparam logic [BIT_TIME_W-1:0] BIT_TIME_TOP   = 20'hFFFFF;
    // 513 empty bytes are 4104 bitcells; at the top bit time that passes 2^32 ns
    localparam int SAT_ZERO_BYTES = 513;
    // at most two bytes held in the block, each with its flush step, with margin
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_BYTES    = 12;
    localparam int LIMIT_CYCLES   = 1000000;

    // one flux interval as it leaves the block
    typedef struct packed {
        logic [ACC_W-1:0] interval_ns;
        logic             run_last;
        logic             track_last;
    } flux_rec_t;

    // how the bitcells of a track are drawn
    typedef enum int {
        STYLE_SPARSE,
        STYLE_MIXED,
        STYLE_DENSE,
        STYLE_EMPTY
    } cell_style_t;

    // tracks the converter's own state and the intervals it still owes us
    class interval_scoreboard_t;
        logic [BIT_TIME_W-1:0] bit_time;
        logic [ACC_W-1:0]      elapsed;
        logic [ACC_W-1:0]      held_gap;
        bit                    held_ok;
        flux_rec_t             due_intervals[$];
        int                    fail_count;
        int                    byte_count;
        int                    track_count;
        int                    checked_count;

        function new();
            bit_time      = BIT_TIME_RESET;
            elapsed       = '0;
            held_gap      = '0;
            held_ok       = 1'b0;
            fail_count    = 0;
            byte_count    = 0;
            track_count   = 0;
            checked_count = 0;
        endfunction

        function void set_bit_time(logic [PDATA_W-1:0] value);
            bit_time = value[BIT_TIME_W-1:0];
        endfunction

        // 32 bit sum that sticks at all ones instead of wrapping
        static function logic [ACC_W-1:0] clamp_add(logic [ACC_W-1:0] a,
                                                    logic [ACC_W-1:0] b);
            logic [ACC_W:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        endfunction

        // walk one byte msb first and queue the intervals it releases
        function void take_cell_byte(logic [CELL_W-1:0] cells, logic last_byte);
            flux_rec_t rec;
            int        queued_before;
            queued_before = due_intervals.size();
            byte_count++;
            for (int b = CELL_W - 1; b >= 0; b--)
            begin
                elapsed = clamp_add(elapsed, ACC_W'(bit_time));
                if (cells[b])
                begin
                    // a transition releases the interval held back one place
                    if (held_ok)
                    begin
                        rec.interval_ns = held_gap;
                        rec.run_last    = 1'b0;
                        rec.track_last  = 1'b0;
                        due_intervals.push_back(rec);
                    end
                    held_gap = elapsed;
                    held_ok  = 1'b1;
                    elapsed  = '0;
                end
            end
            if (last_byte)
            begin
                track_count++;
                // tail time goes onto the final interval; an empty track sends nothing
                if (held_ok)
                begin
                    rec.interval_ns = clamp_add(held_gap, elapsed);
                    rec.run_last    = 1'b0;
                    rec.track_last  = 1'b1;
                    due_intervals.push_back(rec);
                end
                elapsed  = '0;
                held_gap = '0;
                held_ok  = 1'b0;
            end
            if (due_intervals.size() > queued_before)
            begin
                rec = due_intervals.pop_back();
                rec.run_last = 1'b1;
                due_intervals.push_back(rec);
            end
        endfunction

        function void check_interval(flux_rec_t got);
            flux_rec_t want;
            if (due_intervals.size() == 0)
            begin
                $error("unexpected interval: interval_ns %0d run_last %0b track_last %0b",
                       got.interval_ns, got.run_last, got.track_last);
                fail_count++;
                return;
            end
            want = due_intervals.pop_front();
            checked_count++;
            if (got.interval_ns !== want.interval_ns)
            begin
                $error("interval_ns: expected %0d, got %0d", want.interval_ns, got.interval_ns);
                fail_count++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                fail_count++;
            end
            if (got.track_last !== want.track_last)
            begin
                $error("track_last: expected %0b, got %0b", want.track_last, got.track_last);
                fail_count++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 hold_req;

    int                   send_idle_pct = 0;
    int                   stall_pct     = 0;
    int                   cycle_count   = 0;

    interval_scoreboard_t sb = new();

    bcfi_in_if  cell_if ();
    bcfi_out_if flux_if ();

    bitcell_to_flux_intervals uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cell_in      (cell_if),
        .interval_out (flux_if)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog: a hung block or a lost interval ends here
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("bitcell_to_flux_intervals_tb: FAIL");
        $finish;
    end

    // both channels sampled on the edge, before any of this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && cell_if.valid === 1'b1 && cell_if.ready === 1'b1)
            sb.take_cell_byte(cell_if.cell_byte, cell_if.track_end);
        if (rst_n === 1'b1 && flux_if.valid === 1'b1 && flux_if.ready === 1'b1)
            sb.check_interval('{flux_if.interval_ns, flux_if.run_last, flux_if.track_last});
    end

    // output side: random stalls, or one long hold-off on request
    initial
    begin : receiver
        int held_for;
        flux_if.ready <= 1'b0;
        hold_req      <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req      <= 1'b0;
                flux_if.ready <= 1'b0;
                held_for = 0;
                while (held_for < HOLD_CYCLES)
                begin
                    @(posedge clk);
                    held_for++;
                end
            end
            else
                flux_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one byte, with random idle cycles in front, and wait for it to be taken
    task automatic send_byte(logic [CELL_W-1:0] cells, logic last_byte);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cell_if.valid <= 1'b0;
            @(posedge clk);
        end
        cell_if.valid     <= 1'b1;
        cell_if.cell_byte <= cells;
        cell_if.track_end <= last_byte;
        do
            @(posedge clk);
        while (cell_if.ready !== 1'b1);
    endtask

    // drop valid, let every owed interval drain, then give in-flight bytes time to finish
    task automatic settle();
        cell_if.valid <= 1'b0;
        // wait for an edge so the monitor has booked the last accepted byte
        @(posedge clk);
        while (sb.due_intervals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (addr == ADDR_BIT_TIME)
            sb.set_bit_time(data);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // read back the bit time and compare with what the scoreboard believes
    task automatic read_bit_time();
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BIT_TIME;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        got = prdata;
        if (got !== PDATA_W'(sb.bit_time))
        begin
            $error("bit_time: expected %0d, got %0d", sb.bit_time, got);
            sb.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_bit_time(logic [PDATA_W-1:0] value);
        write_reg(ADDR_BIT_TIME, value);
        read_bit_time();
    endtask

    function automatic logic [CELL_W-1:0] pick_cells(cell_style_t style);
        case (style)
            STYLE_EMPTY:  return '0;
            STYLE_SPARSE: return ($urandom_range(5) == 0) ? CELL_W'(1 << $urandom_range(7))
                                                          : '0;
            STYLE_DENSE:  return CELL_W'($urandom | $urandom);
            default:      return CELL_W'($urandom);
        endcase
    endfunction

    // mostly whole tracks with random content; some stray bytes and empty tracks
    task automatic run_random_phase(int quota);
        int          sent;
        int          kind;
        int          len;
        cell_style_t style;
        sent = 0;
        while (sent < quota)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                send_byte(CELL_W'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                style = (kind == 1) ? STYLE_EMPTY : cell_style_t'($urandom_range(2));
                len   = (style == STYLE_SPARSE) ? $urandom_range(30, 1) : $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                    send_byte(pick_cells(style), i == len - 1);
                sent += len;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [PDATA_W-1:0] bt;
        int                 send_tab [8];
        int                 stall_tab[8];

        send_tab  = '{0, 57, 0, 25, 0, 57, 0, 25};
        stall_tab = '{0, 0, 57, 25, 0, 0, 57, 25};

        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cell_if.valid     <= 1'b0;
        cell_if.cell_byte <= '0;
        cell_if.track_end <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register must come out of reset at 4000
        read_bit_time();

        // directed part at the reset bit time, no idling
        send_byte(8'h00, 1'b1);     // track with no transitions: nothing comes out
        send_byte(8'h80, 1'b0);     // first transition is only held
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);     // eight transitions plus the flush: nine intervals
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);     // long tail added to the last interval
        send_byte(8'h01, 1'b1);     // transition on the final cell, no tail
        send_byte(8'h80, 1'b1);     // seven cells of tail
        settle();

        // zero bit time: intervals of 0 ns
        set_bit_time('0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC3, 1'b1);
        settle();

        set_bit_time(PDATA_W'(1));
        send_byte(8'h81, 1'b0);
        send_byte(8'h24, 1'b1);
        settle();

        // a write to an unused address is ignored
        write_reg(ADDR_SPARE, 32'h0001_2345);
        read_bit_time();
        send_byte(8'h11, 1'b1);
        settle();

        // upper data bits beyond the 20 bit field are dropped
        set_bit_time(32'hFFF0_0010);
        send_byte(8'h42, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // saturation: above-range bit time, the accumulator clamps, then the tail sum does
        send_idle_pct = 25;
        stall_pct     = 25;
        set_bit_time(PDATA_W'(BIT_TIME_TOP));
        repeat (SAT_ZERO_BYTES) send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b1);
        settle();

        // random phases, each with its own idling pattern and bit time
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       bt = PDATA_W'(BIT_TIME_MAX);
                1:       bt = PDATA_W'(1);
                3:       bt = '0;
                4:       bt = PDATA_W'(BIT_TIME_RESET);
                6:       bt = PDATA_W'(BIT_TIME_TOP);
                default: bt = PDATA_W'($urandom_range(1000000, 1));
            endcase
            send_idle_pct = send_tab[ph];
            stall_pct     = stall_tab[ph];
            set_bit_time(bt);
            if (ph == 0)
            begin
                // long hold-off while dense bytes keep coming: queue fills, input stalls
                hold_req <= 1'b1;
                for (int i = 0; i < 16; i++)
                    send_byte(pick_cells(STYLE_DENSE), i == 15);
            end
            run_random_phase(PHASE_BYTES);
            settle();
        end

        $display("covered %0d bytes in %0d tracks, %0d intervals checked",
                 sb.byte_count, sb.track_count, sb.checked_count);
        $display("bit times 0 to 1048575, saturation, idle and stall phases, long output hold-off");
        if (sb.fail_count == 0 && sb.due_intervals.size() == 0)
            $display("bitcell_to_flux_intervals_tb: PASS");
        else
            $display("bitcell_to_flux_intervals_tb: FAIL");
        $finish;
    end

endmodule
